/* rtl/egbw_pkg.sv */
// Shared types and constants for the Exp-Golomb bit writer.
package egbw_pkg;

    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 48;
    localparam int NBYTES_W = POS_W - 3;
    localparam int UE_W     = 16;

    // largest code number that still fits a 31-bit ue code
    localparam logic [VALUE_W-1:0] UE_MAX = 32'd65534;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT_BITS = 2'd0,
        REQ_PUT_UE   = 2'd1,
        REQ_TRAILING = 2'd2,
        REQ_ALIGN    = 2'd3
    } req_type_t;

endpackage

/* rtl/exp_golomb_bit_writer_core.sv */
// Exp-Golomb ue(v) and fixed-length bitstream writer, MSB-first byte packer.
//
// Input channel (s_*): one request per item. s_tuser carries the request kind
// (put fixed bits, put ue code, RBSP trailing bits, align); s_tdata carries the
// value and the fixed-put bit count.
// Result channel (m_*): each request yields one result per completed byte, or
// a single empty result (no byte flag) when no byte completes or a ue value is
// rejected. m_tlast marks the final result of a request; every result of a
// request reports the bit position after the whole request.
// The request is held in the input register, then moved into the result
// register, which drives m_*. A request yields 1 to (max(MAX_PUT_BITS,32)+7)/8
// results, 1 to 4 at the default; the result register gives one byte per cycle
// while m_tready is high. The input register takes a new item while the result
// register still drains, so with m_tready high requests follow back to back
// when each completes at most one byte.
// Reset clears the partial byte, the byte counter and both valid flags.
// When the receiver stalls, the current result holds and the input register
// fills, then s_tready drops until the result register frees up.
module exp_golomb_bit_writer_core #(
    parameter int MAX_PUT_BITS = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // value [31:0], bit_count [37:32], zero pad [39:38]
    input  logic [39:0]                             s_tdata,
    // req_type [1:0]
    input  logic [egbw_pkg::REQ_W-1:0]              s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // out_byte [7:0], bit_position [55:8]
    output logic [55:0]                             m_tdata,
    // has_byte [0], error [1]
    output logic [1:0]                              m_tuser,
    output logic                                    m_tlast
);
    import egbw_pkg::*;

    localparam int ACC_W     = ((MAX_PUT_BITS > 32) ? MAX_PUT_BITS : 32) + 7;
    localparam int MAX_BYTES = ACC_W / 8;
    localparam int J         = (MAX_BYTES + 1) * 8;
    localparam int BYTES_W   = MAX_BYTES * 8;
    localparam int NW        = $clog2(J + 1);
    localparam int CW        = $clog2(MAX_BYTES + 1);

    // input register
    logic                   in_valid_reg;
    req_type_t              in_req_reg;
    logic [VALUE_W-1:0]     in_value_reg;
    logic [COUNT_W-1:0]     in_count_reg;

    // writer state
    logic [6:0]             partial_reg, partial_next;
    logic [2:0]             fill_reg, fill_next;
    logic [NBYTES_W-1:0]    byte_count_reg, byte_count_next;

    // result register
    logic                   out_valid_reg;
    logic [BYTES_W-1:0]     out_data_reg;
    logic [CW-1:0]          out_left_reg;
    logic [POS_W-1:0]       out_pos_reg;
    logic                   out_err_reg;

    logic                   out_done;
    logic                   move;

    logic [NW-1:0]          put_len;
    logic [NW-1:0]          total;
    logic [J-1:0]           put_bits;
    logic [J-1:0]           acc;
    logic [J-1:0]           packed_bits;
    logic [CW-1:0]          nb;
    logic                   ue_err;
    logic [UE_W-1:0]        ue_code;
    logic [3:0]             ue_log;

    assign out_done = m_tready && (out_left_reg <= CW'(1));
    assign move     = in_valid_reg && (!out_valid_reg || out_done);
    assign s_tready = !in_valid_reg || move;

    always_comb begin
        ue_code = in_value_reg[UE_W-1:0] + UE_W'(1);
        ue_log  = '0;
        for (int i = 0; i < UE_W; i++) begin
            if (ue_code[i]) begin
                ue_log = 4'(i);
            end
        end
    end

    always_comb begin
        put_len  = '0;
        put_bits = '0;
        ue_err   = 1'b0;
        case (in_req_reg)
            REQ_PUT_BITS: begin
                if (32'(in_count_reg) > MAX_PUT_BITS) begin
                    put_len = NW'(MAX_PUT_BITS);
                end else begin
                    put_len = NW'(in_count_reg);
                end
                put_bits = J'(in_value_reg) & ~({J{1'b1}} << put_len);
            end
            REQ_PUT_UE: begin
                if (in_value_reg > UE_MAX) begin
                    ue_err = 1'b1;
                end else begin
                    put_len  = NW'({ue_log, 1'b1});
                    put_bits = J'(ue_code);
                end
            end
            REQ_TRAILING, REQ_ALIGN: begin
                // align adds nothing on a byte boundary
                if (in_req_reg == REQ_TRAILING || fill_reg != 3'd0) begin
                    put_len  = NW'(4'd8 - {1'b0, fill_reg});
                    put_bits = J'(1) << (put_len - NW'(1));
                end
            end
            default: begin
                put_len = '0;
            end
        endcase

        total           = NW'(fill_reg) + put_len;
        acc             = (J'(partial_reg) << put_len) | put_bits;
        packed_bits     = acc << (NW'(J) - total);
        nb              = CW'(total >> 3);
        fill_next       = total[2:0];
        partial_next    = acc[6:0] & ~(7'h7f << fill_next);
        byte_count_next = byte_count_reg + NBYTES_W'(nb);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            partial_reg    <= '0;
            fill_reg       <= '0;
            byte_count_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (move) begin
                out_valid_reg  <= 1'b1;
                partial_reg    <= partial_next;
                fill_reg       <= fill_next;
                byte_count_reg <= byte_count_next;
            end else if (out_valid_reg && out_done) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg   <= req_type_t'(s_tuser);
            in_value_reg <= s_tdata[VALUE_W-1:0];
            in_count_reg <= s_tdata[VALUE_W +: COUNT_W];
        end
        if (move) begin
            out_data_reg <= packed_bits[J-1 -: BYTES_W];
            out_left_reg <= nb;
            out_pos_reg  <= {byte_count_next, fill_next};
            out_err_reg  <= ue_err;
        end else if (out_valid_reg && m_tready && !out_done) begin
            // advance to the next completed byte
            out_data_reg <= out_data_reg << BYTE_W;
            out_left_reg <= out_left_reg - CW'(1);
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tlast           = out_left_reg <= CW'(1);
    assign m_tuser[0]        = out_left_reg != '0;
    assign m_tuser[1]        = out_err_reg;
    assign m_tdata[7:0]      = (out_left_reg != '0) ? out_data_reg[BYTES_W-1 -: BYTE_W] : '0;
    assign m_tdata[55:8]     = out_pos_reg;

`ifndef SYNTH
    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_left_reg <= CW'(MAX_BYTES))
        else $error("result byte count exceeds the result register");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tlast))
        else $error("rejected request must give one empty final result");

    a_pos_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && $stable(out_pos_reg)))
        else $error("bit position changed within a request");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !move |=> ($stable(byte_count_reg) && $stable(fill_reg)))
        else $error("writer state changed without a request");

    a_no_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && in_valid_reg) |-> !s_tready)
        else $error("input taken while both registers are full");
`endif

endmodule
